// ===== rtl/nfa_pkg.sv =====
// Shared types, constants and helpers of the automaton set simulator.
package nfa_pkg;

	localparam int NUM_STATES = 32;
	localparam int NUM_EDGES  = 64;

	localparam int MODE_W  = 3;
	localparam int SLOT_W  = 6;
	localparam int STATE_W = 5;
	localparam int LABEL_W = 8;

	localparam int STATE_IW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int EDGE_AW  = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LABEL_W;

	localparam logic [LABEL_W-1:0] DEFAULT_EPSILON = 8'd35;

	localparam logic [MODE_W-1:0] MODE_EDGE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MARK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SYMBOL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FINISH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd1;

	typedef logic [NUM_STATES-1:0] state_set_t;
	typedef logic [STATE_IW-1:0]   state_idx_t;
	typedef logic [EDGE_AW-1:0]    edge_addr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_MOVE
	} fsm_state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SLOT_W-1:0]  edge_slot;
		logic [STATE_W-1:0] edge_source;
		logic [STATE_W-1:0] edge_target;
		logic               edge_in_use;
		logic [LABEL_W-1:0] symbol;
		logic [STATE_W-1:0] mark_state;
		logic               mark_value;
	} cmd_t;

	typedef struct packed {
		logic matched;
		logic set_empty;
	} result_t;

	typedef struct packed {
		logic [STATE_W-1:0] init_state;
		logic [LABEL_W-1:0] epsilon_label;
	} cfg_t;

	typedef struct packed {
		logic               we;
		edge_addr_t         addr;
		logic               in_use;
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] dst;
		logic [LABEL_W-1:0] label;
	} edge_wr_t;

	typedef struct packed {
		logic       en;
		edge_addr_t addr;
	} edge_rd_req_t;

	typedef struct packed {
		logic               in_use;
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] dst;
		logic [LABEL_W-1:0] label;
	} edge_rd_t;

	// One-hot set of a state; empty when the index is past the last state.
	function automatic state_set_t state_vec(input logic [STATE_W-1:0] s);
		state_set_t v;
		v = '0;
		if (int'(s) < NUM_STATES) begin
			v[state_idx_t'(s)] = 1'b1;
		end
		return v;
	endfunction

endpackage

// ===== rtl/nfa_edge_mem.sv =====
// Edge table: synchronous memory with registered read and per-entry valid flops.
module nfa_edge_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nfa_pkg::edge_wr_t     wr,
	input  nfa_pkg::edge_rd_req_t rd,
	output nfa_pkg::edge_rd_t     rd_data
);
	import nfa_pkg::*;

	typedef struct packed {
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] dst;
		logic [LABEL_W-1:0] label;
	} edge_entry_t;

	edge_entry_t             edge_ram [NUM_EDGES];
	logic [NUM_EDGES-1:0]    valid_q;
	edge_entry_t             rd_entry_q;
	logic                    rd_valid_q;

	// Payload array: no reset, entries are only trusted behind a valid bit.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			edge_ram[wr.addr] <= '{src: wr.src, dst: wr.dst, label: wr.label};
		end
		if (rd.en) begin
			rd_entry_q <= edge_ram[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr] <= wr.in_use;
			end
			if (rd.en) begin
				rd_valid_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = '{in_use: rd_valid_q, src: rd_entry_q.src,
	                   dst: rd_entry_q.dst, label: rd_entry_q.label};

endmodule

// ===== rtl/nfa_engine.sv =====
// Command sequencer: loads, edge-table scans for closure and move, result word.
module nfa_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  nfa_pkg::cmd_t         cmd,
	input  nfa_pkg::cfg_t         cfg,
	output nfa_pkg::edge_wr_t     mem_wr,
	output nfa_pkg::edge_rd_req_t mem_rd,
	input  nfa_pkg::edge_rd_t     edge_rd,
	output logic                  done,
	output nfa_pkg::result_t      result
);
	import nfa_pkg::*;

	localparam edge_addr_t EDGE_LAST = edge_addr_t'(NUM_EDGES - 1);

	fsm_state_t          state_q, state_d;
	state_set_t          active_q, next_q, accept_q;
	logic                finish_q;
	logic [LABEL_W-1:0]  sym_q;
	edge_addr_t          addr_q;
	logic                issue_q;
	logic                changed_q;
	logic                vld_s1, last_s1;
	logic                done_q;
	result_t             result_q;

	logic        accept, scan_cmd, simple_cmd;
	logic        src_on, eps_fire, mov_fire, grew, pass_end, pass_grew;
	state_set_t  dst_vec, eps_new, next_new;
	logic        scan_restart, finish_out, move_out;
	result_t     simple_res;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign scan_cmd   = (cmd.mode == MODE_SYMBOL) || (cmd.mode == MODE_FINISH);
	assign simple_cmd = accept && !scan_cmd;

	// Edge evaluation on the word read back from the table.
	always_comb begin
		src_on = 1'b0;
		if (int'(edge_rd.src) < NUM_STATES) begin
			src_on = active_q[state_idx_t'(edge_rd.src)];
		end
		dst_vec   = state_vec(edge_rd.dst);
		eps_fire  = vld_s1 && edge_rd.in_use && (edge_rd.label == cfg.epsilon_label) && src_on;
		mov_fire  = vld_s1 && edge_rd.in_use && (edge_rd.label == sym_q) && src_on;
		eps_new   = eps_fire ? (active_q | dst_vec) : active_q;
		next_new  = mov_fire ? (next_q | dst_vec) : next_q;
		grew      = eps_fire && ((dst_vec & ~active_q) != '0);
		pass_end  = vld_s1 && last_s1;
		pass_grew = changed_q || grew;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && scan_cmd) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (pass_end && !pass_grew) begin
					state_d = finish_q ? ST_IDLE : ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (pass_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		scan_restart = 1'b0;
		finish_out   = 1'b0;
		move_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan_restart = accept && scan_cmd;
			end
			ST_CLOSE: begin
				finish_out   = pass_end && !pass_grew && finish_q;
				scan_restart = pass_end && !finish_out;
			end
			ST_MOVE: begin
				move_out = pass_end;
			end
			default: ;
		endcase
	end

	always_comb begin
		simple_res.matched   = 1'b0;
		simple_res.set_empty = (active_q == '0);
		case (cmd.mode)
			MODE_START: simple_res.set_empty = (state_vec(cfg.init_state) == '0);
			default: ;
		endcase
	end

	assign mem_wr = '{we: accept && (cmd.mode == MODE_EDGE) && (int'(cmd.edge_slot) < NUM_EDGES),
	                  addr: edge_addr_t'(cmd.edge_slot), in_use: cmd.edge_in_use,
	                  src: cmd.edge_source, dst: cmd.edge_target, label: cmd.symbol};
	assign mem_rd = '{en: issue_q, addr: addr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= '0;
			next_q    <= '0;
			accept_q  <= '0;
			finish_q  <= 1'b0;
			sym_q     <= '0;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			changed_q <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue_q;
			last_s1 <= (addr_q == EDGE_LAST);
			done_q  <= simple_cmd || finish_out || move_out;

			if (accept) begin
				finish_q <= (cmd.mode == MODE_FINISH);
				sym_q    <= cmd.symbol;
				case (cmd.mode)
					MODE_MARK: begin
						if (int'(cmd.mark_state) < NUM_STATES) begin
							accept_q[state_idx_t'(cmd.mark_state)] <= cmd.mark_value;
						end
					end
					MODE_START: active_q <= state_vec(cfg.init_state);
					default: ;
				endcase
			end

			// Address sweep over the table, one entry a cycle.
			if (scan_restart) begin
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else if (issue_q) begin
				if (addr_q == EDGE_LAST) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end

			if (scan_restart) begin
				changed_q <= 1'b0;
				next_q    <= '0;
			end else begin
				if (grew) begin
					changed_q <= 1'b1;
				end
				if (state_q == ST_MOVE) begin
					next_q <= next_new;
				end
			end

			// Grow the set in place during closure; swap in the move result at its end.
			if (state_q == ST_CLOSE) begin
				active_q <= eps_new;
			end else if (move_out) begin
				active_q <= next_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (simple_cmd) begin
			result_q <= simple_res;
		end else if (finish_out) begin
			result_q <= '{matched: ((eps_new & accept_q) != '0), set_empty: (eps_new == '0)};
		end else if (move_out) begin
			result_q <= '{matched: 1'b0, set_empty: (next_new == '0)};
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/nfa_set_simulation.sv =====
// Top level of the automaton set simulator: ports, configuration registers, wiring.
//
// Drive a command word with start while busy is low; it is taken at that edge.
// Edge writes, accept-mark writes, start-string and unknown commands finish at
// once: the result word shows in the next cycle and busy stays low, so a new
// command may follow every cycle. Symbol and finish commands raise busy and
// sweep the edge table through its single read port, one edge per cycle. The
// epsilon closure repeats sweeps until one adds no state, so it takes (k + 1)
// sweeps when k sweeps grow the set; a symbol adds one more sweep for the
// move. The result word is shown for exactly one cycle with done high, in the
// cycle busy falls; the receiver cannot hold it off, so sample it then. No
// clearing pass follows reset: edge valid bits and accept marks are flops
// cleared by reset. Configuration writes (start state, epsilon label) are
// taken on any edge with cfg_we high; write them only while idle.
module nfa_set_simulation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  nfa_pkg::cmd_t                     cmd,
	output logic                              done,
	output nfa_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [nfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import nfa_pkg::*;

	cfg_t          cfg_q;
	edge_wr_t      mem_wr;
	edge_rd_req_t  mem_rd;
	edge_rd_t      edge_rd;

	// Configuration registers; writes to unused indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_state    <= '0;
			cfg_q.epsilon_label <= DEFAULT_EPSILON;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT_STATE: cfg_q.init_state    <= cfg_wdata[STATE_W-1:0];
				CFG_EPSILON:    cfg_q.epsilon_label <= cfg_wdata[LABEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Edge table memory.
	nfa_edge_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (edge_rd)
	);

	// Sequencer holding the active set and the accept marks.
	nfa_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.cfg     (cfg_q),
		.mem_wr  (mem_wr),
		.mem_rd  (mem_rd),
		.edge_rd (edge_rd),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== rtl/nfa_checker.sv =====
// Port-level checks of the automaton set simulator, bound to its top level.
module nfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input nfa_pkg::cmd_t     cmd,
	input logic              done,
	input nfa_pkg::result_t  result
);
	import nfa_pkg::*;

	// A result word only follows an accepted command or a busy period.
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result word without a command");

	// Load, start and unknown commands answer in the next cycle without a match.
	a_simple_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode != MODE_SYMBOL && cmd.mode != MODE_FINISH)
		|=> (done && !result.matched))
		else $error("load command not answered next cycle");

	// Scan commands go busy first.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.mode == MODE_SYMBOL || cmd.mode == MODE_FINISH))
		|=> (busy && !done))
		else $error("scan command did not go busy");

	// The end of a busy period delivers the result.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A match needs a nonempty set.
	a_match_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.matched) |-> !result.set_empty)
		else $error("match reported on empty set");

endmodule

bind nfa_set_simulation nfa_checker u_nfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
